// ===== rtl/core/pcv_pkg.sv =====
// ----------------------------------------------------------------------------
// pcv_pkg
// Shared types, register codes and constant tables for the masked pixel to
// RGB888 converter.
// ----------------------------------------------------------------------------
package pcv_pkg;

   // Width of a pixel word and of each component mask.
   localparam int unsigned WORD_W = 32;

   // Bits per pixel as held in the size register.
   typedef enum logic [1:0] {
      PIX_8BPP  = 2'd0,
      PIX_16BPP = 2'd1,
      PIX_24BPP = 2'd2,
      PIX_32BPP = 2'd3
   } pix_size_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_RED_MASK   = 3'd0,
      REG_GREEN_MASK = 3'd1,
      REG_BLUE_MASK  = 3'd2,
      REG_PIXEL_SIZE = 3'd3,
      REG_MSB_FIRST  = 3'd4
   } reg_index_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [WORD_W-1:0] red_sel;
      logic [WORD_W-1:0] green_sel;
      logic [WORD_W-1:0] blue_sel;
      pix_size_type      size_mode;
      logic              msb_first;
   } csr_type;

   // Layout controls that the byte packer needs.
   typedef struct packed {
      pix_size_type size_mode;
      logic         msb_first;
   } layout_type;

   // Reciprocals ceil(2^(32+w) / (2^w - 1)) for an exact 32-bit quotient.
   localparam logic [33:0] RECIP_WIDE_W1 = 34'(64'd1 << 33);
   localparam logic [33:0] RECIP_WIDE_W2 = 34'(((64'd1 << 34) + 64'd2) / 64'd3);
   localparam logic [33:0] RECIP_WIDE_W3 = 34'(((64'd1 << 35) + 64'd6) / 64'd7);
   localparam logic [33:0] RECIP_WIDE_W4 = 34'(((64'd1 << 36) + 64'd14) / 64'd15);
   localparam logic [33:0] RECIP_WIDE_W5 = 34'(((64'd1 << 37) + 64'd30) / 64'd31);
   localparam logic [33:0] RECIP_WIDE_W6 = 34'(((64'd1 << 38) + 64'd62) / 64'd63);
   localparam logic [33:0] RECIP_WIDE_W7 = 34'(((64'd1 << 39) + 64'd126) / 64'd127);

   // Reciprocals ceil(2^(15+w) / (2^w - 1)) for an exact 15-bit quotient.
   localparam logic [16:0] RECIP_NARROW_W1 = 17'(64'd1 << 16);
   localparam logic [16:0] RECIP_NARROW_W2 = 17'(((64'd1 << 17) + 64'd2) / 64'd3);
   localparam logic [16:0] RECIP_NARROW_W3 = 17'(((64'd1 << 18) + 64'd6) / 64'd7);
   localparam logic [16:0] RECIP_NARROW_W4 = 17'(((64'd1 << 19) + 64'd14) / 64'd15);
   localparam logic [16:0] RECIP_NARROW_W5 = 17'(((64'd1 << 20) + 64'd30) / 64'd31);
   localparam logic [16:0] RECIP_NARROW_W6 = 17'(((64'd1 << 21) + 64'd62) / 64'd63);
   localparam logic [16:0] RECIP_NARROW_W7 = 17'(((64'd1 << 22) + 64'd126) / 64'd127);

   // Reciprocal for dividing a 32-bit component by 2^w - 1.
   function automatic logic [33:0] recip_wide(input logic [2:0] w);
      case (w)
         3'd1:    return RECIP_WIDE_W1;
         3'd2:    return RECIP_WIDE_W2;
         3'd3:    return RECIP_WIDE_W3;
         3'd4:    return RECIP_WIDE_W4;
         3'd5:    return RECIP_WIDE_W5;
         3'd6:    return RECIP_WIDE_W6;
         3'd7:    return RECIP_WIDE_W7;
         default: return '0;
      endcase
   endfunction

   // Reciprocal for dividing 255 times a remainder by 2^w - 1.
   function automatic logic [16:0] recip_narrow(input logic [2:0] w);
      case (w)
         3'd1:    return RECIP_NARROW_W1;
         3'd2:    return RECIP_NARROW_W2;
         3'd3:    return RECIP_NARROW_W3;
         3'd4:    return RECIP_NARROW_W4;
         3'd5:    return RECIP_NARROW_W5;
         3'd6:    return RECIP_NARROW_W6;
         3'd7:    return RECIP_NARROW_W7;
         default: return '0;
      endcase
   endfunction

   // Largest value of a component of w bits: 2^w - 1.
   function automatic logic [6:0] full_scale(input logic [2:0] w);
      logic [7:0] pow;
      pow = 8'd1 << w;
      return 7'(pow - 8'd1);
   endfunction

endpackage

// ===== rtl/core/pcv_pack.sv =====
// ----------------------------------------------------------------------------
// pcv_pack
// Assembles the pixel word from its memory bytes by pixel size and byte
// order, and registers it at the head of the pipeline.
// ----------------------------------------------------------------------------
module pcv_pack (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [7:0]                      in_byte_zero,
   input  logic [7:0]                      in_byte_one,
   input  logic [7:0]                      in_byte_two,
   input  logic [7:0]                      in_byte_three,
   input  pcv_pkg::layout_type             layout,
   output logic                            out_valid,
   output logic [pcv_pkg::WORD_W-1:0]      out_word
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [pcv_pkg::WORD_W-1:0] word_ff;
   logic [pcv_pkg::WORD_W-1:0] word_in;

   // Pick the byte order and zero the bytes beyond the pixel size.
   always_comb begin
      unique case (layout.size_mode)
         pcv_pkg::PIX_8BPP: begin
            word_in = {24'd0, in_byte_zero};
         end
         pcv_pkg::PIX_16BPP: begin
            word_in = layout.msb_first ? {16'd0, in_byte_zero, in_byte_one}
                                       : {16'd0, in_byte_one, in_byte_zero};
         end
         pcv_pkg::PIX_24BPP: begin
            word_in = layout.msb_first
                    ? {8'd0, in_byte_zero, in_byte_one, in_byte_two}
                    : {8'd0, in_byte_two, in_byte_one, in_byte_zero};
         end
         pcv_pkg::PIX_32BPP: begin
            word_in = layout.msb_first
                    ? {in_byte_zero, in_byte_one, in_byte_two, in_byte_three}
                    : {in_byte_three, in_byte_two, in_byte_one, in_byte_zero};
         end
         default: begin
            word_in = '0;
         end
      endcase
      valid_in = in_valid;
   end

   // Valid bit with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Pixel word register.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/core/pcv_lane.sv =====
// ----------------------------------------------------------------------------
// pcv_lane
// One color component: cuts the field out of the pixel word with its mask and
// expands it to 8 bits, in seven register stages.
// ----------------------------------------------------------------------------
module pcv_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [pcv_pkg::WORD_W-1:0] in_word,
   input  logic [pcv_pkg::WORD_W-1:0] in_mask,
   output logic                       out_valid,
   output logic [7:0]                 out_value
);

   localparam int unsigned STAGES = 7;

   // Position of the lowest set mask bit; zero for an empty mask.
   function automatic logic [4:0] mask_shift(input logic [pcv_pkg::WORD_W-1:0] m);
      logic [4:0] n;
      n = '0;
      for (int i = pcv_pkg::WORD_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            n = 5'(i);
         end
      end
      return n;
   endfunction

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   // Stage A: masked word, shift and width.
   logic [31:0] a_masked_ff, a_masked_in;
   logic [4:0]  a_shift_ff, a_shift_in;
   logic [5:0]  a_width_ff, a_width_in;
   // Stage B: right-aligned component value.
   logic [31:0] b_value_ff, b_value_in;
   logic [5:0]  b_width_ff, b_width_in;
   // Stage C: reciprocal partial products and the wide-field result.
   logic [49:0] c_prod_lo_ff, c_prod_lo_in;
   logic [49:0] c_prod_hi_ff, c_prod_hi_in;
   logic [7:0]  c_top_ff, c_top_in;
   logic [7:0]  c_vlow_ff, c_vlow_in;
   logic [5:0]  c_width_ff, c_width_in;
   // Stage D: low byte of the quotient by the full scale.
   logic [65:0] d_sum;
   logic [7:0]  d_quot_ff, d_quot_in;
   logic [7:0]  d_vlow_ff, d_vlow_in;
   logic [7:0]  d_top_ff, d_top_in;
   logic [5:0]  d_width_ff, d_width_in;
   // Stage E: remainder of that division.
   logic [14:0] e_dq;
   logic [7:0]  e_diff;
   logic [6:0]  e_rem_ff, e_rem_in;
   logic [7:0]  e_quot_ff, e_quot_in;
   logic [7:0]  e_top_ff, e_top_in;
   logic [5:0]  e_width_ff, e_width_in;
   // Stage F: 255 times the remainder, times its reciprocal.
   logic [14:0] f_scaled;
   logic [31:0] f_prod_ff, f_prod_in;
   logic [7:0]  f_quot_ff, f_quot_in;
   logic [7:0]  f_top_ff, f_top_in;
   logic [5:0]  f_width_ff, f_width_in;
   // Stage G: final 8-bit value.
   logic [31:0] g_frac;
   logic [7:0]  g_value_ff, g_value_in;

   // Valid bits travel alongside the data.
   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_comb begin
      // Stage A: apply the mask and measure it.
      a_masked_in = in_word & in_mask;
      a_shift_in  = mask_shift(in_mask);
      a_width_in  = 6'($countones(in_mask));

      // Stage B: align the field to bit zero, gaps kept.
      b_value_in = a_masked_ff >> a_shift_ff;
      b_width_in = a_width_ff;

      // Stage C: multiply by the reciprocal of the full scale in two halves.
      // For fields of eight bits or more only the top byte is kept.
      c_prod_lo_in = {34'd0, b_value_ff[15:0]}
                   * {16'd0, pcv_pkg::recip_wide(b_width_ff[2:0])};
      c_prod_hi_in = {34'd0, b_value_ff[31:16]}
                   * {16'd0, pcv_pkg::recip_wide(b_width_ff[2:0])};
      c_top_in     = 8'(b_value_ff >> (b_width_ff - 6'd8));
      c_vlow_in    = b_value_ff[7:0];
      c_width_in   = b_width_ff;

      // Stage D: combine the halves and take the quotient's low byte.
      d_sum      = {c_prod_hi_ff, 16'd0} + {16'd0, c_prod_lo_ff};
      d_quot_in  = 8'(d_sum >> (6'd32 + {3'd0, c_width_ff[2:0]}));
      d_vlow_in  = c_vlow_ff;
      d_top_in   = c_top_ff;
      d_width_in = c_width_ff;

      // Stage E: the remainder is below 128, so eight bits of it suffice.
      e_dq       = 15'(pcv_pkg::full_scale(d_width_ff[2:0])) * 15'(d_quot_ff);
      e_diff     = d_vlow_ff - e_dq[7:0];
      e_rem_in   = e_diff[6:0];
      e_quot_in  = d_quot_ff;
      e_top_in   = d_top_ff;
      e_width_in = d_width_ff;

      // Stage F: scale the remainder by 255 and divide it by reciprocal.
      f_scaled   = {e_rem_ff, 8'd0} - {8'd0, e_rem_ff};
      f_prod_in  = {17'd0, f_scaled}
                 * {15'd0, pcv_pkg::recip_narrow(e_width_ff[2:0])};
      f_quot_in  = e_quot_ff;
      f_top_in   = e_top_ff;
      f_width_in = e_width_ff;

      // Stage G: 255 times the quotient is minus the quotient modulo 256.
      g_frac = f_prod_ff >> (5'd15 + {2'd0, f_width_ff[2:0]});
      if (f_width_ff == 6'd0) begin
         g_value_in = 8'd0;
      end else if (f_width_ff >= 6'd8) begin
         g_value_in = f_top_ff;
      end else begin
         g_value_in = g_frac[7:0] - f_quot_ff;
      end
   end

   // Valid bits with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Data registers of all stages.
   always_ff @(posedge clock) begin
      a_masked_ff  <= a_masked_in;
      a_shift_ff   <= a_shift_in;
      a_width_ff   <= a_width_in;
      b_value_ff   <= b_value_in;
      b_width_ff   <= b_width_in;
      c_prod_lo_ff <= c_prod_lo_in;
      c_prod_hi_ff <= c_prod_hi_in;
      c_top_ff     <= c_top_in;
      c_vlow_ff    <= c_vlow_in;
      c_width_ff   <= c_width_in;
      d_quot_ff    <= d_quot_in;
      d_vlow_ff    <= d_vlow_in;
      d_top_ff     <= d_top_in;
      d_width_ff   <= d_width_in;
      e_rem_ff     <= e_rem_in;
      e_quot_ff    <= e_quot_in;
      e_top_ff     <= e_top_in;
      e_width_ff   <= e_width_in;
      f_prod_ff    <= f_prod_in;
      f_quot_ff    <= f_quot_in;
      f_top_ff     <= f_top_in;
      f_width_ff   <= f_width_in;
      g_value_ff   <= g_value_in;
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_value = g_value_ff;

endmodule

// ===== rtl/core/masked_pixel_to_rgb888.sv =====
// ----------------------------------------------------------------------------
// masked_pixel_to_rgb888
// Converts the bytes of one framebuffer pixel to 8-bit red, green and blue
// using per-component bit masks.
// ----------------------------------------------------------------------------
// A request is taken in every clock cycle in which start is high; busy is
// always low. Each request gives one result on the rsp_ ports, marked by
// rsp_valid for a single cycle. The request passes the pixel word register,
// which loads at the edge that takes the request, and then the seven register
// stages of the component path, whose depth is set by the exact division by
// 2^width - 1 done with a split reciprocal multiply, a remainder fix-up and a
// second reciprocal multiply. Results come out in request order at one per
// cycle, and the receiver must take each one in its cycle. Configuration
// writes take effect on the next cycle and belong only where no request is
// in flight.
// ----------------------------------------------------------------------------
module masked_pixel_to_rgb888 (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_byte_zero,
   input  logic [7:0]  req_byte_one,
   input  logic [7:0]  req_byte_two,
   input  logic [7:0]  req_byte_three,
   // Result channel.
   output logic        rsp_valid,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   pcv_pkg::csr_type           cfg_ff;
   pcv_pkg::csr_type           cfg_in;
   pcv_pkg::layout_type        layout;
   logic                       pack_valid;
   logic [pcv_pkg::WORD_W-1:0] pack_word;
   logic                       red_valid;
   logic                       green_valid;
   logic                       blue_valid;

   // The pipeline never stalls, so a request is always taken.
   assign busy = 1'b0;

   // Configuration register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pcv_pkg::REG_RED_MASK:   cfg_in.red_sel   = csr_wdata;
            pcv_pkg::REG_GREEN_MASK: cfg_in.green_sel = csr_wdata;
            pcv_pkg::REG_BLUE_MASK:  cfg_in.blue_sel  = csr_wdata;
            pcv_pkg::REG_PIXEL_SIZE: cfg_in.size_mode = pcv_pkg::pix_size_type'(csr_wdata[1:0]);
            pcv_pkg::REG_MSB_FIRST:  cfg_in.msb_first = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Configuration registers; reset gives 32-bit pixels in little-endian order.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_sel   <= 32'h00FF_0000;
         cfg_ff.green_sel <= 32'h0000_FF00;
         cfg_ff.blue_sel  <= 32'h0000_00FF;
         cfg_ff.size_mode <= pcv_pkg::PIX_32BPP;
         cfg_ff.msb_first <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign layout.size_mode = cfg_ff.size_mode;
   assign layout.msb_first = cfg_ff.msb_first;

   // Byte packing stage.
   pcv_pack u_pack (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start & ~busy),
      .in_byte_zero  (req_byte_zero),
      .in_byte_one   (req_byte_one),
      .in_byte_two   (req_byte_two),
      .in_byte_three (req_byte_three),
      .layout        (layout),
      .out_valid     (pack_valid),
      .out_word      (pack_word)
   );

   // One component lane per color.
   pcv_lane u_red (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pack_valid),
      .in_word   (pack_word),
      .in_mask   (cfg_ff.red_sel),
      .out_valid (red_valid),
      .out_value (rsp_red_out)
   );

   pcv_lane u_green (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pack_valid),
      .in_word   (pack_word),
      .in_mask   (cfg_ff.green_sel),
      .out_valid (green_valid),
      .out_value (rsp_green_out)
   );

   pcv_lane u_blue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pack_valid),
      .in_word   (pack_word),
      .in_mask   (cfg_ff.blue_sel),
      .out_valid (blue_valid),
      .out_value (rsp_blue_out)
   );

   // The lanes run in lockstep; their valid bits always agree.
   assign rsp_valid = red_valid & green_valid & blue_valid;

endmodule
